@@ src/cdec_pkg.sv @@
// Shared types, constants and tables for the civil date / epoch converter.
`timescale 1ns / 1ps
package cdec_pkg;

  typedef logic signed [40:0] epoch_t;
  typedef logic signed [15:0] year_t;

  localparam int LAT       = 13;
  localparam int TE_STAGES = 5;

  localparam logic CMD_TO_EPOCH   = 1'b0;
  localparam logic CMD_FROM_EPOCH = 1'b1;

  // Reciprocals: q = (x * M) >> S underestimates by at most one for x < 2**S.
  localparam longint unsigned M675_FULL = (64'd1 << 35) / 675;
  localparam logic [12:0] M675_HI = 13'(M675_FULL >> 13);
  localparam logic [12:0] M675_LO = 13'(M675_FULL & 64'h1FFF);
  localparam logic [7:0]  M_ERA   = 8'((64'd1 << 25) / 146097);
  localparam logic [5:0]  M_3600  = 6'((64'd1 << 17) / 3600);
  localparam logic [6:0]  M_60    = 7'((64'd1 << 12) / 60);
  localparam logic [7:0]  M_1460  = 8'((64'd1 << 18) / 1460);
  localparam logic [2:0]  M_36524 = 3'((64'd1 << 18) / 36524);
  localparam logic [9:0]  M_365   = 10'((64'd1 << 18) / 365);
  localparam logic [8:0]  M_400   = 9'((64'd1 << 17) / 400);
  localparam logic [3:0]  M_153   = 4'((64'd1 << 11) / 153);

  // Bias of 2**24 * 675 keeps the floored seconds/128 value nonnegative.
  localparam logic [34:0] X_BIAS  = 35'd11324620800;
  // The 2**24 bias above, less the day count offset and 100 eras.
  localparam logic [24:0] ZP_SUB  = 25'd1448048;
  localparam logic [7:0]  ERA_BIAS_F = 8'd100;
  localparam logic [16:0] YP_BIAS = 17'd33200;
  localparam logic [16:0] YB_BIAS = 17'd32800;
  localparam logic [8:0]  ERA_BIAS_T = 9'd83;

  // Day of year at the first of a March-based month index.
  function automatic logic [8:0] march_offset(input logic [3:0] mi);
    logic [8:0] r;
    case (mi)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      4'd12:   r = 9'd367;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Month length in a common year, zero for a bad month.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                   r = 5'd30;
      4'd2:                                      r = 5'd28;
      default:                                   r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] div100(input logic [8:0] v);
    logic [1:0] r;
    if (v >= 9'd300) begin
      r = 2'd3;
    end else if (v >= 9'd200) begin
      r = 2'd2;
    end else if (v >= 9'd100) begin
      r = 2'd1;
    end else begin
      r = 2'd0;
    end
    return r;
  endfunction

endpackage

@@ src/cdec_req_if.sv @@
// Request channel: command and civil / epoch input fields.
`timescale 1ns / 1ps
interface cdec_req_if;
  logic                 valid;
  logic                 ready;
  logic                 command;
  cdec_pkg::year_t      year_in;
  logic [3:0]           month_in;
  logic [4:0]           day_in;
  logic [4:0]           hour_in;
  logic [5:0]           minute_in;
  logic [5:0]           second_in;
  cdec_pkg::epoch_t     epoch_in;

  modport source(output valid, command, year_in, month_in, day_in, hour_in, minute_in,
                 second_in, epoch_in, input ready);
  modport sink(input valid, command, year_in, month_in, day_in, hour_in, minute_in,
               second_in, epoch_in, output ready);
endinterface

@@ src/cdec_rsp_if.sv @@
// Response channel: epoch and civil result fields with flags.
`timescale 1ns / 1ps
interface cdec_rsp_if;
  logic                 valid;
  logic                 ready;
  cdec_pkg::epoch_t     epoch_out;
  cdec_pkg::year_t      year_out;
  logic [3:0]           month_out;
  logic [4:0]           day_out;
  logic [4:0]           hour_out;
  logic [5:0]           minute_out;
  logic [5:0]           second_out;
  logic                 civil_valid;
  logic                 range_error;

  modport source(output valid, epoch_out, year_out, month_out, day_out, hour_out,
                 minute_out, second_out, civil_valid, range_error, input ready);
  modport sink(input valid, epoch_out, year_out, month_out, day_out, hour_out,
               minute_out, second_out, civil_valid, range_error, output ready);
endinterface

@@ src/cdec_to_epoch.sv @@
// Civil date-time to epoch seconds pipeline with validity check.
`timescale 1ns / 1ps
module cdec_to_epoch (
  input  logic             clk,
  input  logic             en,
  input  cdec_pkg::year_t  year,
  input  logic [3:0]       month,
  input  logic [4:0]       day,
  input  logic [4:0]       hour,
  input  logic [5:0]       minute,
  input  logic [5:0]       second,
  output cdec_pkg::epoch_t epoch,
  output logic             civil_valid
);
  localparam int PAD = cdec_pkg::LAT - cdec_pkg::TE_STAGES;

  // stage 1
  logic        le2;
  logic [3:0]  mi;
  logic [16:0] yp, yb;
  logic [25:0] pe, pb;
  logic [10:0] doy;
  logic [16:0] tod;
  logic        base_ok;
  logic [16:0] yp_s1, yb_s1, tod_s1;
  logic [8:0]  eq_s1, bq_s1;
  logic [1:0]  ylo_s1;
  logic [10:0] doy_s1;
  logic        base_ok_s1, feb_s1;
  logic [4:0]  len_s1, day_s1;

  always_comb begin
    le2     = month <= 4'd2;
    mi      = le2 ? month + 4'd9 : month - 4'd3;
    yp      = {year[15], year} + cdec_pkg::YP_BIAS - 17'(le2);
    yb      = {year[15], year} + cdec_pkg::YB_BIAS;
    pe      = 26'(yp) * 26'(cdec_pkg::M_400);
    pb      = 26'(yb) * 26'(cdec_pkg::M_400);
    doy     = 11'(cdec_pkg::march_offset(mi)) + 11'(day) - 11'd1;
    tod     = 17'(hour) * 17'd3600 + 17'(minute) * 17'd60 + 17'(second);
    base_ok = (month >= 4'd1) && (month <= 4'd12) && (day != 5'd0) &&
              (hour <= 5'd23) && (minute <= 6'd59) && (second <= 6'd59);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yp_s1      <= yp;
      yb_s1      <= yb;
      eq_s1      <= pe[25:17];
      bq_s1      <= pb[25:17];
      ylo_s1     <= year[1:0];
      doy_s1     <= doy;
      tod_s1     <= tod;
      base_ok_s1 <= base_ok;
      feb_s1     <= month == 4'd2;
      len_s1     <= cdec_pkg::month_len(month);
      day_s1     <= day;
    end
  end

  // stage 2
  logic [16:0] ry, rb;
  logic        gy, gb, leap, cent;
  logic [8:0]  ybr;
  logic [7:0]  era_s2;
  logic [8:0]  yoe_s2;
  logic [10:0] doy_s2;
  logic [16:0] tod_s2;
  logic        ok_s2;

  always_comb begin
    ry   = yp_s1 - 17'(eq_s1) * 17'd400;
    rb   = yb_s1 - 17'(bq_s1) * 17'd400;
    gy   = ry >= 17'd400;
    gb   = rb >= 17'd400;
    ybr  = gb ? 9'(rb - 17'd400) : rb[8:0];
    cent = (ybr == 9'd0) || (ybr == 9'd100) || (ybr == 9'd200) || (ybr == 9'd300);
    leap = ((ylo_s1 == 2'd0) && !cent) || (ybr == 9'd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      era_s2 <= 8'(eq_s1 + 9'(gy));
      yoe_s2 <= gy ? 9'(ry - 17'd400) : ry[8:0];
      doy_s2 <= doy_s1;
      tod_s2 <= tod_s1;
      ok_s2  <= base_ok_s1 && (day_s1 <= len_s1 + 5'(feb_s1 && leap));
    end
  end

  // stage 3
  logic [18:0] doe;
  logic [7:0]  era_s3;
  logic [18:0] doe_s3;
  logic [16:0] tod_s3;
  logic        ok_s3;

  always_comb begin
    doe = 19'(yoe_s2) * 19'd365 + 19'(yoe_s2 >> 2) - 19'(cdec_pkg::div100(yoe_s2)) +
          {{8{doy_s2[10]}}, doy_s2};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      era_s3 <= era_s2;
      doe_s3 <= doe;
      tod_s3 <= tod_s2;
      ok_s3  <= ok_s2;
    end
  end

  // stage 4
  logic signed [8:0]  era_b;
  logic signed [27:0] era_days;
  logic signed [26:0] days;
  logic signed [26:0] days_s4;
  logic [16:0]        tod_s4;
  logic               ok_s4;

  always_comb begin
    era_b    = $signed({1'b0, era_s3}) - $signed(cdec_pkg::ERA_BIAS_T);
    era_days = era_b * 19'sd146097;
    days     = 27'(era_days) + 27'($signed(doe_s3)) - 27'sd719468;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      days_s4 <= days;
      tod_s4  <= tod_s3;
      ok_s4   <= ok_s3;
    end
  end

  // stage 5
  logic signed [44:0] dsec;
  logic [40:0]        secs;
  logic [40:0]        ep_d [PAD+1];
  logic               ok_d [PAD+1];

  always_comb begin
    dsec = days_s4 * 18'sd86400;
    secs = 41'(dsec) + 41'(tod_s4);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ep_d[0] <= secs;
      ok_d[0] <= ok_s4;
      for (int i = 1; i <= PAD; i++) begin
        ep_d[i] <= ep_d[i-1];
        ok_d[i] <= ok_d[i-1];
      end
    end
  end

  assign epoch       = $signed(ep_d[PAD]);
  assign civil_valid = ok_d[PAD];
endmodule

@@ src/cdec_from_epoch.sv @@
// Epoch seconds to civil date-time pipeline with year range check.
`timescale 1ns / 1ps
module cdec_from_epoch (
  input  logic             clk,
  input  logic             en,
  input  cdec_pkg::epoch_t epoch,
  output cdec_pkg::year_t  year,
  output logic [3:0]       month,
  output logic [4:0]       day,
  output logic [4:0]       hour,
  output logic [5:0]       minute,
  output logic [5:0]       second,
  output logic             range_error
);
  // F1: floor(secs / 128) biased positive, split reciprocal products
  logic [34:0] xb;
  logic [47:0] p_hi_s1, p_lo_s1;
  logic [34:0] xb_s1;
  logic [6:0]  lo7_s1;

  assign xb = {epoch[40], epoch[40:7]} + cdec_pkg::X_BIAS;

  always_ff @(posedge clk) begin
    if (en) begin
      p_hi_s1 <= 48'(xb) * 48'(cdec_pkg::M675_HI);
      p_lo_s1 <= 48'(xb) * 48'(cdec_pkg::M675_LO);
      xb_s1   <= xb;
      lo7_s1  <= epoch[6:0];
    end
  end

  // F2
  logic [60:0] psum;
  logic [25:0] q_s2;
  logic [34:0] xb_s2;
  logic [6:0]  lo7_s2;

  assign psum = {p_hi_s1, 13'b0} + 61'(p_lo_s1);

  always_ff @(posedge clk) begin
    if (en) begin
      q_s2   <= psum[60:35];
      xb_s2  <= xb_s1;
      lo7_s2 <= lo7_s1;
    end
  end

  // F3: correct quotient, split into day count and second of day
  logic [34:0] rr;
  logic        g675;
  logic [9:0]  r675;
  logic [24:0] zp_s3;
  logic [16:0] rem_s3;

  always_comb begin
    rr   = xb_s2 - 35'(q_s2) * 35'd675;
    g675 = rr[10:0] >= 11'd675;
    r675 = g675 ? 10'(rr[10:0] - 11'd675) : rr[9:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zp_s3  <= 25'(q_s2 + 26'(g675)) - cdec_pkg::ZP_SUB;
      rem_s3 <= {r675, lo7_s2};
    end
  end

  // F4
  logic [32:0] pz;
  logic [22:0] ph;
  logic [24:0] zp_s4;
  logic [16:0] rem_s4;
  logic [7:0]  eq_s4;
  logic [5:0]  hq_s4;

  always_comb begin
    pz = 33'(zp_s3) * 33'(cdec_pkg::M_ERA);
    ph = 23'(rem_s3) * 23'(cdec_pkg::M_3600);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zp_s4  <= zp_s3;
      rem_s4 <= rem_s3;
      eq_s4  <= pz[32:25];
      hq_s4  <= ph[22:17];
    end
  end

  // F5
  logic [24:0] rz;
  logic [16:0] rh;
  logic        gz, gh;
  logic [7:0]  era_s5;
  logic [17:0] doe_s5;
  logic [4:0]  hour_s5;
  logic [11:0] rs_s5;

  always_comb begin
    rz = zp_s4 - 25'(eq_s4) * 25'd146097;
    rh = rem_s4 - 17'(hq_s4) * 17'd3600;
    gz = rz >= 25'd146097;
    gh = rh >= 17'd3600;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      era_s5  <= eq_s4 + 8'(gz);
      doe_s5  <= gz ? 18'(rz - 25'd146097) : rz[17:0];
      hour_s5 <= 5'(hq_s4 + 6'(gh));
      rs_s5   <= gh ? 12'(rh - 17'd3600) : rh[11:0];
    end
  end

  // F6
  logic [25:0] pa;
  logic [20:0] pb;
  logic [18:0] pm;
  logic [17:0] doe_s6;
  logic [7:0]  aq_s6;
  logic [2:0]  bq_s6;
  logic        c_s6;
  logic [6:0]  mq_s6;
  logic [11:0] rs_s6;
  logic [7:0]  era_s6;
  logic [4:0]  hour_s6;

  always_comb begin
    pa = 26'(doe_s5) * 26'(cdec_pkg::M_1460);
    pb = 21'(doe_s5) * 21'(cdec_pkg::M_36524);
    pm = 19'(rs_s5) * 19'(cdec_pkg::M_60);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      doe_s6  <= doe_s5;
      aq_s6   <= pa[25:18];
      bq_s6   <= pb[20:18];
      c_s6    <= doe_s5 == 18'd146096;
      mq_s6   <= pm[18:12];
      rs_s6   <= rs_s5;
      era_s6  <= era_s5;
      hour_s6 <= hour_s5;
    end
  end

  // F7
  logic [17:0] ra, rb2;
  logic [11:0] rm;
  logic        ga, gb, gm;
  logic [17:0] doe_s7;
  logic [7:0]  a_s7;
  logic [2:0]  b_s7;
  logic        c_s7;
  logic [7:0]  era_s7;
  logic [4:0]  hour_s7;
  logic [5:0]  min_s7, sec_s7;

  always_comb begin
    ra  = doe_s6 - 18'(aq_s6) * 18'd1460;
    rb2 = doe_s6 - 18'(bq_s6) * 18'd36524;
    rm  = rs_s6 - 12'(mq_s6) * 12'd60;
    ga  = ra >= 18'd1460;
    gb  = rb2 >= 18'd36524;
    gm  = rm >= 12'd60;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      doe_s7  <= doe_s6;
      a_s7    <= aq_s6 + 8'(ga);
      b_s7    <= bq_s6 + 3'(gb);
      c_s7    <= c_s6;
      era_s7  <= era_s6;
      hour_s7 <= hour_s6;
      min_s7  <= 6'(mq_s6 + 7'(gm));
      sec_s7  <= gm ? 6'(rm - 12'd60) : rm[5:0];
    end
  end

  // F8
  logic [17:0] t;
  logic [27:0] py;
  logic [17:0] t_s8, doe_s8;
  logic [9:0]  yq_s8;
  logic [7:0]  era_s8;
  logic [4:0]  hour_s8;
  logic [5:0]  min_s8, sec_s8;

  always_comb begin
    t  = doe_s7 - 18'(a_s7) + 18'(b_s7) - 18'(c_s7);
    py = 28'(t) * 28'(cdec_pkg::M_365);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_s8    <= t;
      yq_s8   <= py[27:18];
      doe_s8  <= doe_s7;
      era_s8  <= era_s7;
      hour_s8 <= hour_s7;
      min_s8  <= min_s7;
      sec_s8  <= sec_s7;
    end
  end

  // F9
  logic [17:0] ryr;
  logic        gyr;
  logic [8:0]  yoe_s9;
  logic [17:0] doe_s9;
  logic [7:0]  era_s9;
  logic [4:0]  hour_s9;
  logic [5:0]  min_s9, sec_s9;

  always_comb begin
    ryr = t_s8 - 18'(yq_s8) * 18'd365;
    gyr = ryr >= 18'd365;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      yoe_s9  <= 9'(yq_s8 + 10'(gyr));
      doe_s9  <= doe_s8;
      era_s9  <= era_s8;
      hour_s9 <= hour_s8;
      min_s9  <= min_s8;
      sec_s9  <= sec_s8;
    end
  end

  // F10
  logic [17:0] doy_w;
  logic [8:0]  doy_s10, yoe_s10;
  logic [7:0]  era_s10;
  logic [4:0]  hour_s10;
  logic [5:0]  min_s10, sec_s10;

  assign doy_w = doe_s9 - (18'(yoe_s9) * 18'd365 + 18'(yoe_s9 >> 2) -
                           18'(cdec_pkg::div100(yoe_s9)));

  always_ff @(posedge clk) begin
    if (en) begin
      doy_s10  <= doy_w[8:0];
      yoe_s10  <= yoe_s9;
      era_s10  <= era_s9;
      hour_s10 <= hour_s9;
      min_s10  <= min_s9;
      sec_s10  <= sec_s9;
    end
  end

  // F11
  logic [10:0] n;
  logic [14:0] pn;
  logic [10:0] n_s11;
  logic [3:0]  mq_s11;
  logic [8:0]  doy_s11, yoe_s11;
  logic [7:0]  era_s11;
  logic [4:0]  hour_s11;
  logic [5:0]  min_s11, sec_s11;

  always_comb begin
    n  = 11'(doy_s10) * 11'd5 + 11'd2;
    pn = 15'(n) * 15'(cdec_pkg::M_153);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_s11    <= n;
      mq_s11   <= pn[14:11];
      doy_s11  <= doy_s10;
      yoe_s11  <= yoe_s10;
      era_s11  <= era_s10;
      hour_s11 <= hour_s10;
      min_s11  <= min_s10;
      sec_s11  <= sec_s10;
    end
  end

  // F12
  logic [10:0] rn;
  logic [3:0]  mp;
  logic [3:0]  mp_s12, m_s12;
  logic [8:0]  doy_s12, yoe_s12;
  logic [7:0]  era_s12;
  logic [4:0]  hour_s12;
  logic [5:0]  min_s12, sec_s12;

  always_comb begin
    rn = n_s11 - 11'(mq_s11) * 11'd153;
    mp = mq_s11 + 4'(rn >= 11'd153);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mp_s12   <= mp;
      m_s12    <= (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
      doy_s12  <= doy_s11;
      yoe_s12  <= yoe_s11;
      era_s12  <= era_s11;
      hour_s12 <= hour_s11;
      min_s12  <= min_s11;
      sec_s12  <= sec_s11;
    end
  end

  // F13: final year, range check
  logic [19:0] y;
  logic [8:0]  dw;
  logic        in_rng;

  always_comb begin
    y      = (20'(era_s12) - 20'(cdec_pkg::ERA_BIAS_F)) * 20'd400 + 20'(yoe_s12) +
             20'(m_s12 <= 4'd2);
    dw     = doy_s12 - cdec_pkg::march_offset(mp_s12) + 9'd1;
    in_rng = (y[19:15] == 5'b00000) || (y[19:15] == 5'b11111);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      year        <= in_rng ? $signed(y[15:0]) : 16'sd0;
      month       <= in_rng ? m_s12 : 4'd0;
      day         <= in_rng ? dw[4:0] : 5'd0;
      range_error <= !in_rng;
      hour        <= hour_s12;
      minute      <= min_s12;
      second      <= sec_s12;
    end
  end
endmodule

@@ src/civil_date_epoch_converter.sv @@
// Top level: civil date-time <-> epoch seconds converter.
// 13 register stages lie between the request transaction and the response valid.
// Throughput: one transaction per cycle; the whole pipeline holds while a
// response waits, and request ready follows that hold.
// Reset clears the valid pipeline only; no clearing pass.
`timescale 1ns / 1ps
module civil_date_epoch_converter (
  input logic     clk,
  input logic     rst,
  cdec_req_if.sink   req,
  cdec_rsp_if.source rsp
);
  localparam int L = cdec_pkg::LAT;

  logic [L-1:0]      vld;
  logic [L-1:0]      cmd;
  logic              en;
  cdec_pkg::epoch_t  te_epoch;
  logic              te_ok;
  cdec_pkg::year_t   fe_year;
  logic [3:0]        fe_month;
  logic [4:0]        fe_day, fe_hour;
  logic [5:0]        fe_minute, fe_second;
  logic              fe_rerr;
  logic              fwd;

  assign en        = !vld[L-1] || rsp.ready;
  assign req.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[L-2:0], req.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd <= {cmd[L-2:0], req.command};
    end
  end

  cdec_to_epoch u_to_epoch (
    .clk         (clk),
    .en          (en),
    .year        (req.year_in),
    .month       (req.month_in),
    .day         (req.day_in),
    .hour        (req.hour_in),
    .minute      (req.minute_in),
    .second      (req.second_in),
    .epoch       (te_epoch),
    .civil_valid (te_ok)
  );

  cdec_from_epoch u_from_epoch (
    .clk         (clk),
    .en          (en),
    .epoch       (req.epoch_in),
    .year        (fe_year),
    .month       (fe_month),
    .day         (fe_day),
    .hour        (fe_hour),
    .minute      (fe_minute),
    .second      (fe_second),
    .range_error (fe_rerr)
  );

  assign fwd = cmd[L-1] == cdec_pkg::CMD_FROM_EPOCH;

  assign rsp.valid       = vld[L-1];
  assign rsp.epoch_out   = fwd ? '0 : te_epoch;
  assign rsp.civil_valid = fwd ? 1'b0 : te_ok;
  assign rsp.year_out    = fwd ? fe_year : '0;
  assign rsp.month_out   = fwd ? fe_month : 4'd0;
  assign rsp.day_out     = fwd ? fe_day : 5'd0;
  assign rsp.hour_out    = fwd ? fe_hour : 5'd0;
  assign rsp.minute_out  = fwd ? fe_minute : 6'd0;
  assign rsp.second_out  = fwd ? fe_second : 6'd0;
  assign rsp.range_error = fwd ? fe_rerr : 1'b0;
endmodule

@@ src/cdec_checker.sv @@
// Port-level checks for the converter, bound to the top level.
`timescale 1ns / 1ps
module cdec_checker (
  input logic             clk,
  input logic             rst,
  input logic             rsp_valid,
  input logic             rsp_ready,
  input cdec_pkg::epoch_t epoch_out,
  input cdec_pkg::year_t  year_out,
  input logic [3:0]       month_out,
  input logic [4:0]       day_out,
  input logic [4:0]       hour_out,
  input logic [5:0]       minute_out,
  input logic [5:0]       second_out,
  input logic             civil_valid,
  input logic             range_error
);
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response dropped while stalled");

  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid right after reset");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && civil_valid |-> !range_error && month_out == 4'd0 && day_out == 5'd0)
    else $error("civil result carries date fields");

  a_rerr_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && range_error |-> year_out == 16'sd0 && month_out == 4'd0 &&
    day_out == 5'd0 && epoch_out == 41'sd0)
    else $error("range error with nonzero date fields");

  a_tod_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> hour_out <= 5'd23 && minute_out <= 6'd59 && second_out <= 6'd59)
    else $error("time of day out of range");
endmodule

bind civil_date_epoch_converter cdec_checker u_cdec_checker (
  .clk         (clk),
  .rst         (rst),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .epoch_out   (rsp.epoch_out),
  .year_out    (rsp.year_out),
  .month_out   (rsp.month_out),
  .day_out     (rsp.day_out),
  .hour_out    (rsp.hour_out),
  .minute_out  (rsp.minute_out),
  .second_out  (rsp.second_out),
  .civil_valid (rsp.civil_valid),
  .range_error (rsp.range_error)
);
